FILE: sv/bfp_pkg.sv
// Shared constants, register codes and types of the Bloom filter probe core.
// No dependencies; every other file refers to it by scoped names.
package bfp_pkg;

  localparam int unsigned HashWidth    = 64;
  localparam int unsigned ModWidth     = 17;
  localparam int unsigned CountWidth   = 6;
  localparam int unsigned IndexWidth   = 10;
  localparam int unsigned WordWidth    = 64;
  localparam int unsigned BitSelWidth  = 6;
  localparam int unsigned RoundsWidth  = 7;

  // Remainder digits retired by a reduction unit in one clock.
  localparam int unsigned DigitsPerStep = 4;
  localparam int unsigned ReduceCycles  = HashWidth / DigitsPerStep;

  localparam int unsigned FilterWordsDefault = 1024;
  localparam int unsigned MaxHashesDefault   = 32;

  // Input tdata layout, lowest field first.
  localparam int unsigned InIndexLsb   = 0;
  localparam int unsigned InDataLsb    = InIndexLsb + IndexWidth;
  localparam int unsigned InLowLsb     = InDataLsb + WordWidth;
  localparam int unsigned InHighLsb    = InLowLsb + HashWidth;
  localparam int unsigned InUsedBits   = InHighLsb + HashWidth;
  localparam int unsigned InTdataWidth = ((InUsedBits + 7) / 8) * 8;
  localparam int unsigned OutTdataWidth = 8;

  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = ModWidth;
  localparam logic [CfgIndexWidth-1:0] CfgFilterBits = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CfgHashCount  = 1'd1;

  localparam logic [ModWidth-1:0]   FilterBitsReset = 17'd65536;
  localparam logic [CountWidth-1:0] HashCountReset  = 6'd1;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic                done;
    logic [ModWidth-1:0] rem;
  } red_status_t;

endpackage

FILE: sv/bfp_mod_reduce.sv
// Multi-cycle reduction of a 64-bit value modulo a 17-bit modulus.
// Restoring remainder, several digits per clock. Uses bfp_pkg.
module bfp_mod_reduce (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bfp_pkg::HashWidth-1:0] dividend_i,
  input  logic [bfp_pkg::ModWidth-1:0]  modulus_i,
  output bfp_pkg::red_status_t          status_o
);

  localparam int unsigned CntWidth = $clog2(bfp_pkg::ReduceCycles);
  localparam logic [CntWidth-1:0] LastCnt = CntWidth'(bfp_pkg::ReduceCycles - 1);

  logic [bfp_pkg::HashWidth-1:0] sh_q, sh_d;
  logic [bfp_pkg::ModWidth-1:0]  rem_q, rem_d;
  logic [CntWidth-1:0]           cnt_q;
  logic                          busy_q, done_q;

  always_comb begin
    logic [bfp_pkg::ModWidth:0] trial;
    rem_d = rem_q;
    for (int k = 0; k < int'(bfp_pkg::DigitsPerStep); k++) begin
      trial = {rem_d, sh_q[bfp_pkg::HashWidth-1-k]};
      if (trial >= {1'b0, modulus_i}) begin
        trial = trial - {1'b0, modulus_i};
      end
      rem_d = trial[bfp_pkg::ModWidth-1:0];
    end
    sh_d = sh_q << bfp_pkg::DigitsPerStep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign status_o.done = done_q;
  assign status_o.rem  = rem_q;

endmodule

FILE: sv/bfp_filter_mem.sv
// Filter word store: one write port, one read port, registered read data.
// Uses bfp_pkg for the word width.
module bfp_filter_mem #(
  parameter int unsigned Depth     = bfp_pkg::FilterWordsDefault,
  parameter int unsigned AddrWidth = 10
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrWidth-1:0]          waddr_i,
  input  logic [bfp_pkg::WordWidth-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AddrWidth-1:0]          raddr_i,
  output logic [bfp_pkg::WordWidth-1:0] rdata_o
);

  logic [bfp_pkg::WordWidth-1:0] mem_q [Depth];
  logic [bfp_pkg::WordWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bloom_filter_probe_core.sv
// Top level of the Bloom filter probe core: stream ports, configuration,
// query sequencer. Uses bfp_pkg, bfp_mod_reduce and bfp_filter_mem.
//
// Input items arrive on the s_axis group; tuser is the opcode. A load whose
// index lies within the store writes one 64-bit word into it and gives no
// result. A query gives one result on the m_axis group, maybe_present in
// tdata bit 0. A query holds the input side through these steps, ending
// early on a miss: the accepting cycle, a reduction phase in
// which three remainder units (four digits a cycle, then a handover) reduce
// the base, the stride and 2^64 modulo the bit count, then a probe loop that
// issues one filter store read per cycle, tracking the probe position as a
// running residue, and stops at the first clear bit or a position past the
// store. The store's registered read data is checked after the last read, and
// a finish state then moves the result into the output register. Items are
// taken one at a time: tready is high only while no query is in progress.
// Because loads and queries never overlap, store accesses cannot collide.
// The result sits in an output register; the core accepts further items
// while it waits, and a query that finishes while the register is still
// full holds until the receiver takes the old result.
// Reset clears the control state, sets the bit count to 65536 and the hash
// count to 1; the filter store is not cleared and must be loaded before use.
// Configuration writes are taken on every edge with cfg_we_i high; the user
// must make them only while the core is idle, and the core does not enforce this.
module bloom_filter_probe_core #(
  parameter int unsigned FILTER_WORDS = bfp_pkg::FilterWordsDefault,
  parameter int unsigned MAX_HASHES   = bfp_pkg::MaxHashesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // word_index, word_data, base hash, stride hash, zero pad (lowest bit first)
  input  logic [bfp_pkg::InTdataWidth-1:0]  s_axis_tdata,
  // opcode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // maybe_present, zero pad (lowest bit first)
  output logic [bfp_pkg::OutTdataWidth-1:0] m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [bfp_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [bfp_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int unsigned MW = bfp_pkg::ModWidth;
  localparam int unsigned HW = bfp_pkg::HashWidth;
  localparam int unsigned RW = bfp_pkg::RoundsWidth;
  localparam int unsigned AddrWidth = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
  localparam logic [MW-1:0] WordsLimit = MW'(FILTER_WORDS);
  localparam logic [RW-1:0] RoundsLimit = RW'(MAX_HASHES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REDUCE = 2'd1;
  localparam logic [1:0] S_PROBE  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [MW-1:0]                   bits_q;
  logic [bfp_pkg::CountWidth-1:0]  hashes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q   <= bfp_pkg::FilterBitsReset;
      hashes_q <= bfp_pkg::HashCountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bfp_pkg::CfgFilterBits: bits_q   <= cfg_data_i;
        bfp_pkg::CfgHashCount:  hashes_q <= cfg_data_i[bfp_pkg::CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [bfp_pkg::IndexWidth-1:0] in_index;
  logic [bfp_pkg::WordWidth-1:0]  in_word;
  logic [HW-1:0]                  in_low, in_high;

  assign in_index = s_axis_tdata[bfp_pkg::InIndexLsb +: bfp_pkg::IndexWidth];
  assign in_word  = s_axis_tdata[bfp_pkg::InDataLsb +: bfp_pkg::WordWidth];
  assign in_low   = s_axis_tdata[bfp_pkg::InLowLsb +: HW];
  assign in_high  = s_axis_tdata[bfp_pkg::InHighLsb +: HW];

  logic in_xfer, load_xfer, query_xfer;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_xfer     = in_xfer && (s_axis_tuser == bfp_pkg::OpLoad);
  assign query_xfer    = in_xfer && (s_axis_tuser == bfp_pkg::OpQuery);

  // Query context.
  logic [MW-1:0] mod_q, mod_d;
  logic [RW-1:0] rounds_q, rounds_d;
  logic [HW-1:0] hash_q, stride_q;

  assign mod_d    = (bits_q == '0) ? MW'(1) : bits_q;
  assign rounds_d = ({1'b0, hashes_q} > RoundsLimit) ? RoundsLimit : {1'b0, hashes_q};

  // Remainder units: base, stride and 2^64 - 1.
  bfp_pkg::red_status_t red_low, red_high, red_ones;

  bfp_mod_reduce u_red_low (
    .clk_i, .rst_ni, .start_i(query_xfer), .dividend_i(in_low),
    .modulus_i(mod_q), .status_o(red_low)
  );
  bfp_mod_reduce u_red_high (
    .clk_i, .rst_ni, .start_i(query_xfer), .dividend_i(in_high),
    .modulus_i(mod_q), .status_o(red_high)
  );
  bfp_mod_reduce u_red_ones (
    .clk_i, .rst_ni, .start_i(query_xfer), .dividend_i({HW{1'b1}}),
    .modulus_i(mod_q), .status_o(red_ones)
  );

  // The units read the registered modulus, which is captured from the
  // configuration on the accepting edge of a query, as the units start.
  logic [MW-1:0] red_mod;
  assign red_mod = mod_q;

  // Probe loop state: residue, stride residue, and 2^64 mod m for wraps.
  logic [MW-1:0] r_q, s_q, c_q;
  logic [RW-1:0] issued_q;
  logic          pend_q, pend_in_range_q;
  logic [bfp_pkg::BitSelWidth-1:0] pend_bit_q;
  logic          hit_q;

  logic [MW:0]   ones_inc;
  logic [MW-1:0] c_init;
  assign ones_inc = {1'b0, red_ones.rem} + 1'b1;
  assign c_init   = (ones_inc == {1'b0, red_mod}) ? '0 : ones_inc[MW-1:0];

  logic [HW:0]   hash_sum;
  logic [MW:0]   r_sum, r_fix;
  logic [MW-1:0] r_step, r_next;
  logic [MW-1:0] word_of_r;
  logic          r_in_range;

  assign hash_sum = {1'b0, hash_q} + {1'b0, stride_q};
  assign r_sum    = {1'b0, r_q} + {1'b0, s_q};
  assign r_step   = (r_sum >= {1'b0, red_mod}) ? MW'(r_sum - {1'b0, red_mod}) : r_sum[MW-1:0];
  // A wrap of the 64-bit sum removes 2^64, i.e. c from the residue.
  assign r_fix    = (r_step >= c_q) ? {1'b0, r_step - c_q}
                                    : ({1'b0, r_step} + {1'b0, red_mod} - {1'b0, c_q});
  assign r_next   = hash_sum[HW] ? r_fix[MW-1:0] : r_step;

  assign word_of_r  = MW'(r_q[MW-1:bfp_pkg::BitSelWidth]);
  assign r_in_range = (word_of_r < WordsLimit);

  logic [bfp_pkg::WordWidth-1:0] mem_rdata;
  logic miss_now, issue, probe_done;

  assign miss_now   = pend_q && !(pend_in_range_q && mem_rdata[pend_bit_q]);
  assign issue      = (state_q == S_PROBE) && (issued_q < rounds_q) && !miss_now;
  assign probe_done = (state_q == S_PROBE) && (miss_now || (issued_q == rounds_q));

  // Filter store.
  logic [MW-1:0] load_word;
  logic          mem_we;
  assign load_word = MW'(in_index);
  assign mem_we    = load_xfer && (load_word < WordsLimit);

  bfp_filter_mem #(
    .Depth    (FILTER_WORDS),
    .AddrWidth(AddrWidth)
  ) u_mem (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(load_word[AddrWidth-1:0]),
    .wdata_i(in_word),
    .re_i   (issue && r_in_range),
    .raddr_i(word_of_r[AddrWidth-1:0]),
    .rdata_o(mem_rdata)
  );

  // Output register.
  logic out_valid_q, out_bit_q;
  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (query_xfer) state_d = S_REDUCE;
      S_REDUCE: if (red_low.done) state_d = S_PROBE;
      S_PROBE:  if (probe_done) state_d = S_FINISH;
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      issued_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_REDUCE) begin
        pend_q   <= 1'b0;
        issued_q <= '0;
      end else if (state_q == S_PROBE) begin
        pend_q <= issue;
        if (issue) begin
          issued_q <= issued_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_xfer) begin
      mod_q    <= mod_d;
      rounds_q <= rounds_d;
      hash_q   <= in_low;
      stride_q <= in_high;
    end
    if (state_q == S_REDUCE && red_low.done) begin
      r_q <= red_low.rem;
      s_q <= red_high.rem;
      c_q <= c_init;
    end else if (issue) begin
      r_q    <= r_next;
      hash_q <= hash_sum[HW-1:0];
    end
    if (issue) begin
      pend_bit_q      <= r_q[bfp_pkg::BitSelWidth-1:0];
      pend_in_range_q <= r_in_range;
    end
    if (probe_done) begin
      hit_q <= !miss_now;
    end
    if (state_q == S_FINISH && out_free) begin
      out_bit_q <= hit_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(bfp_pkg::OutTdataWidth - 1)'(0), out_bit_q};

  // The three remainder units run in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (red_low.done == red_high.done) && (red_low.done == red_ones.done))
    else $error("remainder units out of step");

  // The running residue is always a proper remainder during the probe loop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (r_q < mod_q))
    else $error("probe residue not below modulus");

  // The loop never issues more probes than the clamped hash count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (issued_q <= rounds_q))
    else $error("too many probes issued");

  // A new result only appears after a query has finished its probe loop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_FINISH))
    else $error("result without a finished query");

endmodule
